// ===== hdl/cfb_pkg.sv =====
package cfb_pkg;

  localparam logic [1:0] LayoutGeneral = 2'd0;
  localparam logic [1:0] LayoutRadio   = 2'd1;
  localparam logic [1:0] LayoutKeypad  = 2'd2;
  localparam logic [1:0] LayoutNone    = 2'd3;

  localparam logic [15:0] CrcPoly  = 16'h1021;
  localparam logic [7:0]  SyncByte = 8'h7E;
  localparam logic [7:0]  HdrByte  = 8'h0B;
  localparam logic [7:0]  PadByte  = 8'h00;

  localparam int IdxW = 5;
  localparam logic [IdxW-1:0] LastIdxShort = 5'd16;
  localparam logic [IdxW-1:0] LastIdxLong  = 5'd18;
  localparam logic [IdxW-1:0] CrcStartType = 5'd6;
  localparam logic [IdxW-1:0] CrcStartBody = 5'd7;

  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = 1;
  localparam int QueueCntW  = 2;

  typedef struct packed {
    logic [1:0]      layout;
    logic [IdxW-1:0] last_idx;
    logic [7:0]      msg_type;
    logic [15:0]     dev_id;
    logic [15:0]     command_code;
    logic [15:0]     data_word;
    logic [15:0]     seq_no;
    logic [7:0]      byte_a;
    logic [7:0]      byte_b;
    logic [7:0]      byte_c;
    logic [7:0]      byte_d;
  } entry_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/cfb_ifs.sv =====
interface cfb_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  msg_type;
  logic [15:0] dev_id;
  logic [15:0] command_code;
  logic [15:0] data_word;
  logic [15:0] seq_no;
  logic [7:0]  byte_a;
  logic [7:0]  byte_b;
  logic [7:0]  byte_c;
  logic [7:0]  byte_d;

  modport source (
    output valid, cmd, msg_type, dev_id, command_code, data_word, seq_no,
           byte_a, byte_b, byte_c, byte_d,
    input  ready
  );
  modport sink (
    input  valid, cmd, msg_type, dev_id, command_code, data_word, seq_no,
           byte_a, byte_b, byte_c, byte_d,
    output ready
  );
endinterface

interface cfb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink (input valid, out_byte, last, output ready);
endinterface

// ===== hdl/cfb_front.sv =====
module cfb_front (
  cfb_cmd_if.sink          command,
  input  logic             q_ready,
  output logic             push,
  output cfb_pkg::entry_t  entry
);
  import cfb_pkg::*;

  assign command.ready = q_ready;
  assign push = command.valid && q_ready && (command.cmd != LayoutNone);

  always_comb begin
    entry.layout       = command.cmd;
    entry.last_idx     = (command.cmd == LayoutRadio) ? LastIdxLong : LastIdxShort;
    entry.msg_type     = command.msg_type;
    entry.dev_id       = command.dev_id;
    entry.command_code = command.command_code;
    entry.data_word    = command.data_word;
    entry.seq_no       = command.seq_no;
    entry.byte_a       = command.byte_a;
    entry.byte_b       = command.byte_b;
    entry.byte_c       = command.byte_c;
    entry.byte_d       = command.byte_d;
  end

endmodule

// ===== hdl/cfb_queue.sv =====
module cfb_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  cfb_pkg::entry_t  push_entry,
  output logic             push_ready,
  output logic             pop_valid,
  input  logic             pop,
  output cfb_pkg::entry_t  pop_entry
);
  import cfb_pkg::*;

  entry_t                slots [QueueDepth];
  logic [QueuePtrW-1:0]  wptr;
  logic [QueuePtrW-1:0]  rptr;
  logic [QueueCntW-1:0]  count;

  assign push_ready = (count != QueueCntW'(QueueDepth));
  assign pop_valid  = (count != '0);
  assign pop_entry  = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_entry;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !push_ready))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !pop_valid))
    else $error("queue read while empty");
`endif

endmodule

// ===== hdl/cfb_back.sv =====
module cfb_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  cfb_pkg::entry_t  q_entry,
  output logic             pop,
  cfb_byte_if.source       frame
);
  import cfb_pkg::*;

  entry_t           cur;
  logic             busy;
  logic [IdxW-1:0]  idx;
  logic [15:0]      crc;
  logic             ovalid;
  logic [7:0]       obyte;
  logic             olast;

  logic             load;
  logic             emit;
  logic             fin;
  logic [7:0]       sel;
  logic [IdxW-1:0]  crc_start;
  logic [IdxW-1:0]  crc_end;
  logic             in_crc;

  assign frame.valid    = ovalid;
  assign frame.out_byte = obyte;
  assign frame.last     = olast;

  assign load = !ovalid || frame.ready;
  assign emit = load && busy;
  assign fin  = emit && (idx == cur.last_idx);
  assign pop  = q_valid && load && (!busy || fin);

  assign crc_start = (cur.layout == LayoutGeneral) ? CrcStartType : CrcStartBody;
  assign crc_end   = cur.last_idx - IdxW'(2);
  assign in_crc    = (idx >= crc_start) && (idx <= crc_end);

  always_comb begin
    case (idx)
      5'd0, 5'd1, 5'd2, 5'd3: sel = SyncByte;
      5'd4:  sel = HdrByte;
      5'd5:  sel = PadByte;
      5'd6:  sel = cur.msg_type;
      5'd7:  sel = cur.dev_id[7:0];
      5'd8:  sel = cur.dev_id[15:8];
      5'd9:  sel = cur.command_code[7:0];
      5'd10: sel = cur.command_code[15:8];
      5'd11: sel = (cur.layout == LayoutGeneral) ? cur.data_word[7:0] : cur.byte_a;
      5'd12: sel = (cur.layout == LayoutGeneral) ? cur.data_word[15:8] : cur.byte_b;
      5'd13: sel = (cur.layout == LayoutRadio) ? cur.byte_c : cur.seq_no[7:0];
      5'd14: sel = (cur.layout == LayoutRadio) ? cur.byte_d : cur.seq_no[15:8];
      5'd15: sel = (cur.layout == LayoutRadio) ? cur.seq_no[7:0] : crc[7:0];
      5'd16: sel = (cur.layout == LayoutRadio) ? cur.seq_no[15:8] : crc[15:8];
      5'd17: sel = crc[7:0];
      5'd18: sel = crc[15:8];
      default: sel = PadByte;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      ovalid <= 1'b0;
      idx    <= '0;
    end else begin
      if (load) begin
        ovalid <= emit;
      end
      if (pop) begin
        busy <= 1'b1;
        idx  <= '0;
      end else begin
        if (fin) begin
          busy <= 1'b0;
        end
        if (emit) begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      obyte <= sel;
      olast <= fin;
    end
    if (pop) begin
      cur <= q_entry;
      crc <= '0;
    end else if (emit && in_crc) begin
      crc <= crc_byte(crc, sel);
    end
  end

`ifndef SYNTH
  a_idx_in_frame: assert property (@(posedge clk) disable iff (rst)
    busy |-> (idx <= cur.last_idx))
    else $error("byte index beyond end of frame");
  a_restart_at_zero: assert property (@(posedge clk) disable iff (rst)
    fin |=> (!busy || idx == '0))
    else $error("next frame does not start at its first byte");
`endif

endmodule

// ===== hdl/command_frame_builder_crc16.sv =====
// Takes one command word and sends it as a byte frame: preamble 7E 7E 7E 7E 0B 00, the type
// byte, the layout's fields low byte first, and a CRC-16 (polynomial 0x1021, initial value
// zero) low byte first, with last set on the final byte. The general and keypad layouts
// give 17 bytes and the radio layout 19; a command with the unused layout code is taken
// and dropped without any output. The serialiser emits one byte per cycle while the output
// is ready, and frames that are queued follow each other with no gap; after idle, a command
// passes through the queue slot, the current-frame register and the output byte register.
// A two-word queue lets the next commands be taken while a frame is still going out.
module command_frame_builder_crc16 (
  input  logic        clk,
  input  logic        rst,
  cfb_cmd_if.sink     command,
  cfb_byte_if.source  frame
);
  import cfb_pkg::*;

  logic   push;
  logic   q_ready;
  logic   q_valid;
  logic   pop;
  entry_t push_entry;
  entry_t pop_entry;

  cfb_front u_front (
    .command (command),
    .q_ready (q_ready),
    .push    (push),
    .entry   (push_entry)
  );

  cfb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (q_ready),
    .pop_valid  (q_valid),
    .pop        (pop),
    .pop_entry  (pop_entry)
  );

  cfb_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_entry (pop_entry),
    .pop     (pop),
    .frame   (frame)
  );

endmodule
